@@ sv/quaternion_to_euler_angles_macros.svh @@
// assertion macros for the quaternion to euler angles block
// included by the rtl files that carry concurrent assertions
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

`ifndef SYNTHESIS

`define Q2E_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("q2e assertion failed");

`define Q2E_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("q2e assertion failed");

`else

`define Q2E_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define Q2E_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/q2e_pkg.sv @@
// shared constants and the cordic angle table for the quaternion to euler block
// no dependencies
package q2e_pkg;

    localparam int NORM_LOG    = 40;
    localparam int CORD_W      = 45;
    localparam int ANG_OUT_W   = 16;
    localparam int PITCH_OUT_W = 15;
    localparam int UNITS_TURN  = 46080;
    localparam int PITCH_LIMIT = 11520;
    localparam int ANG_LIMIT   = 23040;

    localparam logic [31:0] TURN_TABLE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    // atan(2^-i) as a binary angle of aw bits, rounded half up
    function automatic longint step_angle(input int i, input int aw);
        longint t;
        t = longint'(TURN_TABLE[i[4:0]]);
        if (aw >= 32) begin
            return t;
        end
        return (t + (longint'(1) << (31 - aw))) >>> (32 - aw);
    endfunction

endpackage

@@ sv/q2e_if.sv @@
// valid/ready channel interfaces for quaternion input and euler angle output beats
// depends on q2e_pkg
interface q2e_quat_if #(parameter int QUAT_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [QUAT_WIDTH-1:0] quat_x;
    logic signed [QUAT_WIDTH-1:0] quat_y;
    logic signed [QUAT_WIDTH-1:0] quat_z;
    logic signed [QUAT_WIDTH-1:0] quat_w;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface q2e_euler_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [q2e_pkg::PITCH_OUT_W-1:0] pitch_deg;
    logic signed [q2e_pkg::ANG_OUT_W-1:0]   yaw_deg;
    logic signed [q2e_pkg::ANG_OUT_W-1:0]   roll_deg;

    modport source (output valid, pitch_deg, yaw_deg, roll_deg, input ready);
    modport sink (input valid, pitch_deg, yaw_deg, roll_deg, output ready);
endinterface

@@ sv/quaternion_to_euler_angles.sv @@
// One quaternion beat (Q2.14 by default) enters per clock and one euler angle beat
// leaves per clock; depth is set by the square-root digit cells for pitch and the
// cordic cell rows of the three atan2 lanes. Whole pipe stalls only while an output
// beat is held by the sink. Roll enable is a single bit written by i_cfg_we.
// depends on q2e_pkg, q2e_if, q2e_sqrt_cell, q2e_atan
`include "quaternion_to_euler_angles_macros.svh"

module quaternion_to_euler_angles #(
    parameter int QUAT_WIDTH    = 16,
    parameter int ANGLE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    q2e_quat_if.sink    i_quat,
    q2e_euler_if.source o_euler
);
    import q2e_pkg::*;

    localparam int PROD_FRAC = 2 * (QUAT_WIDTH - 2);
    localparam int SHIFT_DN  = (PROD_FRAC > 28) ? PROD_FRAC - 28 : 0;
    localparam int INT_FRAC  = PROD_FRAC - SHIFT_DN;
    localparam int PW        = 2 * QUAT_WIDTH - SHIFT_DN;
    localparam int SW        = PW + 3;
    localparam int SQW       = INT_FRAC + 1;
    localparam int RW        = 2 * INT_FRAC + 1;
    localparam int NSQ       = INT_FRAC + 1;
    localparam int DLY       = INT_FRAC + 3;
    localparam int LL        = CORDIC_STAGES + 9;
    localparam int N         = DLY + LL + 3;
    localparam logic signed [SW-1:0]    ONE    = SW'(1) <<< INT_FRAC;
    localparam logic [2*SQW-1:0]        ONE_SQ = (2*SQW)'(1) << (2 * INT_FRAC);
    localparam logic signed [ANG_OUT_W-1:0] PLIM = ANG_OUT_W'(PITCH_LIMIT);

    typedef struct packed {
        logic signed [SW-1:0] sinr;
        logic signed [SW-1:0] cosr;
        logic signed [SW-1:0] siny;
        logic signed [SW-1:0] cosy;
        logic signed [SW-1:0] sinp;
        logic                 sat;
    } t_ops;

    function automatic logic signed [PW-1:0] mul_down(
        input logic signed [QUAT_WIDTH-1:0] a,
        input logic signed [QUAT_WIDTH-1:0] b
    );
        logic signed [2*QUAT_WIDTH-1:0] f;
        f = a * b;
        return PW'(f >>> SHIFT_DN);
    endfunction

    logic                 en;
    logic [N-1:0]         r_vld;
    logic                 r_roll_en;
    logic signed [PW-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    t_ops                 n_ops;
    t_ops                 r_ops;
    t_ops                 r_dly [DLY];
    logic [1:0]           r_pf [LL];
    logic signed [SQW-1:0] n_s;
    logic [2*SQW-1:0]     r_sq;
    logic [2*SQW-1:0]     n_rem;
    logic [RW-1:0]        r_rem;
    logic [RW-1:0]        sv_v [NSQ+1];
    logic [RW:0]          sv_r [NSQ+1];
    logic signed [SW-1:0] n_root;
    logic signed [ANG_OUT_W-1:0] u_pitch, u_yaw, u_roll;
    logic signed [ANG_OUT_W-1:0] n_pitch;
    logic signed [ANG_OUT_W-1:0] n_pneg;
    logic signed [PITCH_OUT_W-1:0] r_pitch;
    logic signed [ANG_OUT_W-1:0] r_yaw;
    logic signed [ANG_OUT_W-1:0] r_roll;

    assign en           = ~r_vld[N-1] | o_euler.ready;
    assign i_quat.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_roll_en <= 1'b1;
        end else begin
            if (en) begin
                r_vld <= {r_vld[N-2:0], i_quat.valid};
            end
            if (i_cfg_we) begin
                r_roll_en <= i_cfg_wdata;
            end
        end
    end

    // product terms
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= mul_down(i_quat.quat_w, i_quat.quat_x);
            r_yz <= mul_down(i_quat.quat_y, i_quat.quat_z);
            r_xx <= mul_down(i_quat.quat_x, i_quat.quat_x);
            r_yy <= mul_down(i_quat.quat_y, i_quat.quat_y);
            r_wy <= mul_down(i_quat.quat_w, i_quat.quat_y);
            r_zx <= mul_down(i_quat.quat_z, i_quat.quat_x);
            r_wz <= mul_down(i_quat.quat_w, i_quat.quat_z);
            r_xy <= mul_down(i_quat.quat_x, i_quat.quat_y);
            r_zz <= mul_down(i_quat.quat_z, i_quat.quat_z);
        end
    end

    always_comb begin
        n_ops.sinr = (SW'(r_wx) + SW'(r_yz)) <<< 1;
        n_ops.cosr = ONE - ((SW'(r_xx) + SW'(r_yy)) <<< 1);
        n_ops.sinp = (SW'(r_wy) - SW'(r_zx)) <<< 1;
        n_ops.siny = (SW'(r_wz) + SW'(r_xy)) <<< 1;
        n_ops.cosy = ONE - ((SW'(r_yy) + SW'(r_zz)) <<< 1);
        n_ops.sat  = (n_ops.sinp >= ONE) || (n_ops.sinp <= -ONE);
    end

    assign n_s   = r_ops.sinp[SQW-1:0];
    assign n_rem = ONE_SQ - r_sq;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ops    <= n_ops;
            r_sq     <= n_s * n_s;
            r_rem    <= n_rem[RW-1:0];
            r_dly[0] <= r_ops;
            for (int k = 1; k < DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    // square root of 1 - sinp^2 for the pitch cosine
    assign sv_v[0] = r_rem;
    assign sv_r[0] = '0;

    for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
        q2e_sqrt_cell #(.VW(RW), .B(INT_FRAC - j)) u_sqrt (
            .i_clk (i_clk),
            .i_en  (en),
            .i_v   (sv_v[j]),
            .i_res (sv_r[j]),
            .o_v   (sv_v[j+1]),
            .o_res (sv_r[j+1])
        );
    end

    assign n_root = SW'($signed({1'b0, sv_r[NSQ][INT_FRAC:0]}));

    q2e_atan #(.IN_W(SW), .ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch_lane (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_dly[DLY-1].sinp),
        .i_x     (n_root),
        .o_units (u_pitch)
    );

    q2e_atan #(.IN_W(SW), .ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw_lane (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_dly[DLY-1].siny),
        .i_x     (r_dly[DLY-1].cosy),
        .o_units (u_yaw)
    );

    q2e_atan #(.IN_W(SW), .ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_roll_lane (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_dly[DLY-1].sinr),
        .i_x     (r_dly[DLY-1].cosr),
        .o_units (u_roll)
    );

    // saturation flag and sign ride alongside the lanes
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pf[0] <= {r_dly[DLY-1].sat, r_dly[DLY-1].sinp[SW-1]};
            for (int k = 1; k < LL; k++) begin
                r_pf[k] <= r_pf[k-1];
            end
        end
    end

    always_comb begin
        if (r_pf[LL-1][1]) begin
            n_pitch = r_pf[LL-1][0] ? -PLIM : PLIM;
        end else if (u_pitch > PLIM) begin
            n_pitch = PLIM;
        end else if (u_pitch < -PLIM) begin
            n_pitch = -PLIM;
        end else begin
            n_pitch = u_pitch;
        end
        n_pneg = -n_pitch;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pitch <= n_pneg[PITCH_OUT_W-1:0];
            r_yaw   <= u_yaw;
            r_roll  <= r_roll_en ? -u_roll : '0;
        end
    end

    assign o_euler.valid     = r_vld[N-1];
    assign o_euler.pitch_deg = r_pitch;
    assign o_euler.yaw_deg   = r_yaw;
    assign o_euler.roll_deg  = r_roll;

    `Q2E_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, !en, $stable(r_vld))
    `Q2E_ASSERT_NXT(a_beat_enter, i_clk, i_rst_n, i_quat.valid && i_quat.ready, r_vld[0])
    `Q2E_ASSERT_IMP(a_pitch_range, i_clk, i_rst_n, o_euler.valid, (o_euler.pitch_deg <= PITCH_LIMIT) && (o_euler.pitch_deg >= -PITCH_LIMIT))
    `Q2E_ASSERT_IMP(a_yaw_range, i_clk, i_rst_n, o_euler.valid, (o_euler.yaw_deg <= ANG_LIMIT) && (o_euler.yaw_deg >= -ANG_LIMIT))
endmodule

@@ sv/q2e_norm_cell.sv @@
// normalize cell: scales an atan2 operand pair by 2^K while both stay in range
// depends on q2e_pkg
module q2e_norm_cell #(
    parameter int K = 1
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [q2e_pkg::CORD_W-1:0]   i_x,
    input  logic signed [q2e_pkg::CORD_W-1:0]   i_y,
    output logic signed [q2e_pkg::CORD_W-1:0]   o_x,
    output logic signed [q2e_pkg::CORD_W-1:0]   o_y
);
    import q2e_pkg::*;

    localparam logic signed [CORD_W-1:0] LIM = CORD_W'(1) <<< (NORM_LOG + 1 - K);

    logic                     n_small;
    logic signed [CORD_W-1:0] r_x;
    logic signed [CORD_W-1:0] r_y;

    assign n_small = (i_x < LIM) && (i_x > -LIM) && (i_y < LIM) && (i_y > -LIM);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_small ? (i_x <<< K) : i_x;
            r_y <= n_small ? (i_y <<< K) : i_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
endmodule

@@ sv/q2e_cordic_cell.sv @@
// one vectoring cordic cell: rotates by atan(2^-I) toward the x axis
// depends on q2e_pkg
module q2e_cordic_cell #(
    parameter int I  = 0,
    parameter int AW = 16
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [q2e_pkg::CORD_W-1:0] i_x,
    input  logic signed [q2e_pkg::CORD_W-1:0] i_y,
    input  logic signed [AW+1:0]              i_z,
    output logic signed [q2e_pkg::CORD_W-1:0] o_x,
    output logic signed [q2e_pkg::CORD_W-1:0] o_y,
    output logic signed [AW+1:0]              o_z
);
    import q2e_pkg::*;

    localparam logic signed [AW+1:0] STEP = (AW+2)'(step_angle(I, AW));

    logic signed [CORD_W-1:0] n_dx;
    logic signed [CORD_W-1:0] n_dy;
    logic signed [CORD_W-1:0] r_x;
    logic signed [CORD_W-1:0] r_y;
    logic signed [AW+1:0]     r_z;

    assign n_dx = i_y >>> I;
    assign n_dy = i_x >>> I;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_y > 0) begin
                r_x <= i_x + n_dx;
                r_y <= i_y - n_dy;
                r_z <= i_z + STEP;
            end else if (i_y < 0) begin
                r_x <= i_x - n_dx;
                r_y <= i_y + n_dy;
                r_z <= i_z - STEP;
            end else begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= i_z;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

@@ sv/q2e_sqrt_cell.sv @@
// one digit cell of a restoring integer square root, digit weight 4^B
// no dependencies
module q2e_sqrt_cell #(
    parameter int VW = 57,
    parameter int B  = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [VW-1:0] i_v,
    input  logic [VW:0]   i_res,
    output logic [VW-1:0] o_v,
    output logic [VW:0]   o_res
);
    localparam logic [VW+1:0] BIT = (VW+2)'(1) << (2 * B);

    logic [VW+1:0] n_trial;
    logic [VW+1:0] n_diff;
    logic [VW-1:0] r_v;
    logic [VW:0]   r_res;

    assign n_trial = {1'b0, i_res} + BIT;
    assign n_diff  = {2'b00, i_v} - n_trial;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if ({2'b00, i_v} >= n_trial) begin
                r_v   <= n_diff[VW-1:0];
                r_res <= (i_res >> 1) + BIT[VW:0];
            end else begin
                r_v   <= i_v;
                r_res <= i_res >> 1;
            end
        end
    end

    assign o_v   = r_v;
    assign o_res = r_res;
endmodule

@@ sv/q2e_atan.sv @@
// atan2 lane: normalize cells, half-turn fold, cordic cell row, clamp and scale to 1/128 degree
// depends on q2e_pkg, q2e_norm_cell, q2e_cordic_cell
module q2e_atan #(
    parameter int IN_W          = 35,
    parameter int ANGLE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [IN_W-1:0]               i_y,
    input  logic signed [IN_W-1:0]               i_x,
    output logic signed [q2e_pkg::ANG_OUT_W-1:0] o_units
);
    import q2e_pkg::*;

    localparam int ZW = ANGLE_WIDTH + 2;
    localparam int NN = 6;
    localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (ANGLE_WIDTH - 1);
    localparam logic signed [16:0] UNITS = 17'(UNITS_TURN);
    localparam logic signed [ANGLE_WIDTH+17:0] RND = (ANGLE_WIDTH+18)'(1) <<< (ANGLE_WIDTH - 1);

    logic signed [CORD_W-1:0] nx [NN+1];
    logic signed [CORD_W-1:0] ny [NN+1];
    logic signed [CORD_W-1:0] cx [CORDIC_STAGES+1];
    logic signed [CORD_W-1:0] cy [CORDIC_STAGES+1];
    logic signed [ZW-1:0]     cz [CORDIC_STAGES+1];
    logic signed [CORD_W-1:0] r_qx;
    logic signed [CORD_W-1:0] r_qy;
    logic signed [ZW-1:0]     r_qz;
    logic signed [ANGLE_WIDTH:0]     r_a;
    logic signed [ANGLE_WIDTH+17:0]  n_prod;
    logic signed [ANGLE_WIDTH+17:0]  n_sum;
    logic signed [ANG_OUT_W-1:0]     r_units;

    assign nx[0] = CORD_W'(i_x);
    assign ny[0] = CORD_W'(i_y);

    for (genvar j = 0; j < NN; j++) begin : g_norm
        q2e_norm_cell #(.K(32 >> j)) u_norm (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x   (nx[j]),
            .i_y   (ny[j]),
            .o_x   (nx[j+1]),
            .o_y   (ny[j+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (nx[NN] < 0) begin
                r_qx <= -nx[NN];
                r_qy <= -ny[NN];
                r_qz <= (ny[NN] >= 0) ? HALF : -HALF;
            end else begin
                r_qx <= nx[NN];
                r_qy <= ny[NN];
                r_qz <= '0;
            end
        end
    end

    assign cx[0] = r_qx;
    assign cy[0] = r_qy;
    assign cz[0] = r_qz;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        q2e_cordic_cell #(.I(i), .AW(ANGLE_WIDTH)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x   (cx[i]),
            .i_y   (cy[i]),
            .i_z   (cz[i]),
            .o_x   (cx[i+1]),
            .o_y   (cy[i+1]),
            .o_z   (cz[i+1])
        );
    end

    assign n_prod = r_a * UNITS;
    assign n_sum  = n_prod + RND;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (cz[CORDIC_STAGES] > HALF) begin
                r_a <= HALF[ANGLE_WIDTH:0];
            end else if (cz[CORDIC_STAGES] < -HALF) begin
                r_a <= (ANGLE_WIDTH+1)'(-HALF);
            end else begin
                r_a <= cz[CORDIC_STAGES][ANGLE_WIDTH:0];
            end
            r_units <= ANG_OUT_W'(n_sum >>> ANGLE_WIDTH);
        end
    end

    assign o_units = r_units;
endmodule
